// File: hdl/hex_lattice_gas_particle_step_assert.svh
// -----------------------------------------------------------------------------
// Assertion macros for the hexagonal lattice gas particle step block
// Concurrent check macros shared by the controller and the datapath.
// -----------------------------------------------------------------------------
`ifndef HEX_LATTICE_GAS_PARTICLE_STEP_ASSERT_SVH
`define HEX_LATTICE_GAS_PARTICLE_STEP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HLG_ASSERT_HOLD(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
	else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HLG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
	else $error(msg);

`endif

// File: hdl/hlg_pkg.sv
// -----------------------------------------------------------------------------
// hlg_pkg
// Types, codes and small helper functions shared by the lattice gas modules.
// -----------------------------------------------------------------------------
`default_nettype none

package hlg_pkg;

	// Fixed port field widths.
	localparam int MODE_W     = 2;
	localparam int PART_PW    = 11;
	localparam int SITE_PW    = 12;
	localparam int SPIN_W     = 3;
	localparam int TURN_W     = 4;

	// Command codes carried in the mode field.
	localparam logic [MODE_W-1:0] MODE_PLACE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_STEP  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

	// Lattice directions in steps of sixty degrees; up is the previous row.
	localparam logic [SPIN_W-1:0] DIR_E  = 3'd0;
	localparam logic [SPIN_W-1:0] DIR_UR = 3'd1;
	localparam logic [SPIN_W-1:0] DIR_UL = 3'd2;
	localparam logic [SPIN_W-1:0] DIR_W  = 3'd3;
	localparam logic [SPIN_W-1:0] DIR_DL = 3'd4;
	localparam logic [SPIN_W-1:0] DIR_DR = 3'd5;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PLACE,
		ST_RDOCC,
		ST_RDRES,
		ST_ZERO,
		ST_PREAD,
		ST_DIV1,
		ST_DIV2,
		ST_NEIGH,
		ST_TREAD,
		ST_DECIDE,
		ST_MOVE
	} hlg_state_t;

	typedef enum logic [2:0] {
		RES_NONE,
		RES_PLACE,
		RES_READ,
		RES_STEP,
		RES_ZERO
	} hlg_res_t;

	typedef struct packed {
		logic     load;
		logic     clr;
		logic     prd;
		logic     div1;
		logic     div2;
		logic     neigh;
		logic     ord_site;
		logic     ord_target;
		logic     place_wr;
		logic     vacate;
		logic     occupy;
		logic     pwr_step;
		hlg_res_t res;
	} hlg_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic p_ok;
		logic target_free;
	} hlg_status_t;

	// Reduces a three-bit orientation modulo six.
	function automatic logic [SPIN_W-1:0] mod6_u3(input logic [SPIN_W-1:0] v);
		mod6_u3 = (v >= 3'd6) ? v - 3'd6 : v;
	endfunction

	// New spin: (spin + (turn rem 6)) mod 6, the remainder taking the sign of turn.
	function automatic logic [SPIN_W-1:0] turn_spin(input logic [SPIN_W-1:0] sp,
		input logic [TURN_W-1:0] t);
		logic [TURN_W-1:0] mag;
		logic [TURN_W-1:0] r;
		logic [4:0]        sum;
		logic [SPIN_W-1:0] base;
		base = mod6_u3(sp);
		mag  = t[TURN_W-1] ? (4'd0 - t) : t;
		r    = (mag >= 4'd6) ? mag - 4'd6 : mag;
		if (t[TURN_W-1]) begin
			sum = 5'(base) + 5'd6 - 5'(r);
		end else begin
			sum = 5'(base) + 5'(r);
		end
		if (sum >= 5'd6) begin
			sum = sum - 5'd6;
		end
		turn_spin = sum[SPIN_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: hdl/hex_lattice_gas_particle_step.sv
// -----------------------------------------------------------------------------
// hex_lattice_gas_particle_step
// One Monte Carlo update of an active lattice gas on a toroidal hexagonal lattice.
// -----------------------------------------------------------------------------
//
// Channel   Direction  Handshake           Fields
// command   in         start && !busy      mode particle site spin_in turn
//                                          random_walk random_dir
// result    out        done (one cycle)    site_out spin_out moved occupied
//
// Sequence: a transaction is taken in an idle cycle; place, a site read or a step then
// runs through its controller states, after which busy falls in the cycle in which done
// shows the result.
// The step is set by the controller's sequence of memory accesses: particle
// word read, row and column recovery in two steps through one multiplier each,
// neighbour address, occupancy read, then up to two occupancy writes on a single port.
// Stepping a particle index beyond the particle store, and mode three, give an all-zero result.
// Reset: after arst_n is released the occupancy memory is cleared one site per cycle,
// every one of the ROWS * COLS sites, with busy high all the while.
// The receiver cannot stall: done marks each result for exactly one cycle.
// -----------------------------------------------------------------------------
`default_nettype none

module hex_lattice_gas_particle_step
	import hlg_pkg::*;
#(
	parameter int SIDE          = 16,
	parameter int MAX_PARTICLES = 2048
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic [MODE_W-1:0]         mode,
	input  wire logic [PART_PW-1:0]        particle,
	input  wire logic [SITE_PW-1:0]        site,
	input  wire logic [SPIN_W-1:0]         spin_in,
	input  wire logic signed [TURN_W-1:0]  turn,
	input  wire logic                      random_walk,
	input  wire logic [SPIN_W-1:0]         random_dir,
	output logic                           done,
	output logic [SITE_PW-1:0]             site_out,
	output logic [SPIN_W-1:0]              spin_out,
	output logic                           moved,
	output logic                           occupied
);

	// The controller sequences each transaction; the datapath holds both memories.
	hlg_cmd_t    cmd;
	hlg_status_t status;

	hlg_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// The turn is carried as raw bits; the spin arithmetic reads its sign bit.
	hlg_dp #(
		.SIDE          (SIDE),
		.MAX_PARTICLES (MAX_PARTICLES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.particle    (particle),
		.site        (site),
		.spin_in     (spin_in),
		.turn        ($unsigned(turn)),
		.random_walk (random_walk),
		.random_dir  (random_dir),
		.done        (done),
		.site_out    (site_out),
		.spin_out    (spin_out),
		.moved       (moved),
		.occupied    (occupied)
	);

endmodule

`default_nettype wire

// File: hdl/hlg_ctrl.sv
// -----------------------------------------------------------------------------
// hlg_ctrl
// Sequencer for the clearing pass, the place, read and step commands and mode three.
// -----------------------------------------------------------------------------
`default_nettype none

module hlg_ctrl
	import hlg_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [MODE_W-1:0] mode,
	input  wire hlg_status_t       status,
	output hlg_cmd_t               cmd,
	output logic                   busy
);

	hlg_state_t state_q;
	hlg_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (status.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					case (mode)
						MODE_PLACE: state_d = ST_PLACE;
						MODE_STEP:  state_d = ST_PREAD;
						MODE_READ:  state_d = ST_RDOCC;
						default:    state_d = ST_ZERO;
					endcase
				end
			end
			ST_PLACE:  state_d = ST_IDLE;
			ST_RDOCC:  state_d = ST_RDRES;
			ST_RDRES:  state_d = ST_IDLE;
			ST_ZERO:   state_d = ST_IDLE;
			ST_PREAD:  state_d = status.p_ok ? ST_DIV1 : ST_IDLE;
			ST_DIV1:   state_d = ST_DIV2;
			ST_DIV2:   state_d = ST_NEIGH;
			ST_NEIGH:  state_d = ST_TREAD;
			ST_TREAD:  state_d = ST_DECIDE;
			ST_DECIDE: state_d = status.target_free ? ST_MOVE : ST_IDLE;
			ST_MOVE:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = (state_q != ST_IDLE);
		case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
			end
			ST_IDLE: begin
				cmd.load = start;
			end
			ST_PLACE: begin
				cmd.place_wr = 1'b1;
				cmd.res      = RES_PLACE;
			end
			ST_RDOCC: begin
				cmd.ord_site = 1'b1;
			end
			ST_RDRES: begin
				cmd.res = RES_READ;
			end
			ST_ZERO: begin
				cmd.res = RES_ZERO;
			end
			ST_PREAD: begin
				if (status.p_ok) begin
					cmd.prd = 1'b1;
				end else begin
					cmd.res = RES_ZERO;
				end
			end
			ST_DIV1: begin
				cmd.div1 = 1'b1;
			end
			ST_DIV2: begin
				cmd.div2 = 1'b1;
			end
			ST_NEIGH: begin
				cmd.neigh = 1'b1;
			end
			ST_TREAD: begin
				cmd.ord_target = 1'b1;
			end
			ST_DECIDE: begin
				if (status.target_free) begin
					cmd.vacate = 1'b1;
				end else begin
					cmd.pwr_step = 1'b1;
					cmd.res      = RES_STEP;
				end
			end
			ST_MOVE: begin
				cmd.occupy   = 1'b1;
				cmd.pwr_step = 1'b1;
				cmd.res      = RES_STEP;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

`include "hex_lattice_gas_particle_step_assert.svh"

	`HLG_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy,
		"accepted transaction did not make the block busy")
	`HLG_ASSERT_NEXT(a_vacate_then_occupy, clk, arst_n, cmd.vacate, cmd.occupy,
		"vacated site not followed by occupying the target")
	`HLG_ASSERT_NEXT(a_blocked_ends, clk, arst_n,
		(state_q == ST_DECIDE) && !status.target_free, state_q == ST_IDLE,
		"blocked step did not finish after the decision")

endmodule

`default_nettype wire

// File: hdl/hlg_dp.sv
// -----------------------------------------------------------------------------
// hlg_dp
// Lattice memories, site decomposition, neighbour selection and result register.
// -----------------------------------------------------------------------------
`default_nettype none

module hlg_dp
	import hlg_pkg::*;
#(
	parameter int SIDE          = 16,
	parameter int MAX_PARTICLES = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire hlg_cmd_t                 cmd,
	output hlg_status_t                   status,
	input  wire logic [PART_PW-1:0]       particle,
	input  wire logic [SITE_PW-1:0]       site,
	input  wire logic [SPIN_W-1:0]        spin_in,
	input  wire logic [TURN_W-1:0]        turn,
	input  wire logic                     random_walk,
	input  wire logic [SPIN_W-1:0]        random_dir,
	output logic                          done,
	output logic [SITE_PW-1:0]            site_out,
	output logic [SPIN_W-1:0]             spin_out,
	output logic                          moved,
	output logic                          occupied
);

	localparam int COLS    = 6 * SIDE;
	localparam int ROWS    = 2 * SIDE;
	localparam int NSITES  = ROWS * COLS;
	localparam int SITE_W  = $clog2(NSITES);
	localparam int ROW_W   = $clog2(ROWS);
	localparam int COL_W   = $clog2(COLS);
	localparam int PIDX_W  = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
	localparam int PWORD_W = SITE_W + SPIN_W;
	localparam int RECIP   = (1 << SITE_W) / COLS;

	localparam logic [SITE_W-1:0] COLS_V    = SITE_W'(COLS);
	localparam logic [SITE_W-1:0] SITE_LAST = SITE_W'(NSITES - 1);
	localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
	localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLS - 1);

	// Latched command fields.
	logic [PART_PW-1:0] particle_q;
	logic [SITE_PW-1:0] site_q;
	logic [SPIN_W-1:0]  spin_in_q;
	logic [TURN_W-1:0]  turn_q;
	logic               rw_q;
	logic [SPIN_W-1:0]  rdir_q;

	// Step working registers.
	logic [PWORD_W-1:0] prd_q;
	logic [ROW_W-1:0]   qest_q;
	logic [SPIN_W-1:0]  spin_new_q;
	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic [SITE_W-1:0]  target_q;
	logic               occ_rd_q;
	logic [SITE_W-1:0]  clr_q;

	logic               occ_mem [NSITES];
	logic [PWORD_W-1:0] part_mem [MAX_PARTICLES];

	logic               site_ok;
	logic               p_ok;
	logic [SITE_W-1:0]  site_addr;
	logic [PIDX_W-1:0]  p_addr;
	logic [SITE_W-1:0]  loc;
	logic [SPIN_W-1:0]  spin_old;
	logic [SITE_W-1:0]  final_site;

	assign site_ok    = (32'(site_q) < 32'(NSITES));
	assign p_ok       = (32'(particle_q) < 32'(MAX_PARTICLES));
	assign site_addr  = SITE_W'(site_q);
	assign p_addr     = PIDX_W'(particle_q);
	assign loc        = prd_q[PWORD_W-1:SPIN_W];
	assign spin_old   = prd_q[SPIN_W-1:0];
	assign final_site = occ_rd_q ? loc : target_q;

	assign status.clr_last    = (clr_q == SITE_LAST);
	assign status.p_ok        = p_ok;
	assign status.target_free = !occ_rd_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			particle_q <= particle;
			site_q     <= site;
			spin_in_q  <= mod6_u3(spin_in);
			turn_q     <= turn;
			rw_q       <= random_walk;
			rdir_q     <= mod6_u3(random_dir);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// Row estimate by reciprocal multiplication; it is the row or one below it.
	logic [2*SITE_W-1:0] prod;
	assign prod = (2*SITE_W)'(loc) * (2*SITE_W)'(RECIP);

	always_ff @(posedge clk) begin
		if (cmd.div1) begin
			qest_q     <= prod[SITE_W +: ROW_W];
			spin_new_q <= turn_spin(spin_old, turn_q);
		end
	end

	logic [SITE_W-1:0] rem;
	logic [SITE_W-1:0] rem_fix;
	assign rem     = loc - (SITE_W'(qest_q) * COLS_V);
	assign rem_fix = rem - COLS_V;

	always_ff @(posedge clk) begin
		if (cmd.div2) begin
			if (rem >= COLS_V) begin
				row_q <= qest_q + 1'b1;
				col_q <= rem_fix[COL_W-1:0];
			end else begin
				row_q <= qest_q;
				col_q <= rem[COL_W-1:0];
			end
		end
	end

	// Neighbour on the torus; even rows sit half a site to the right.
	logic [SPIN_W-1:0] dir;
	logic              even;
	logic [ROW_W-1:0]  up;
	logic [ROW_W-1:0]  down;
	logic [COL_W-1:0]  right;
	logic [COL_W-1:0]  left;
	logic [ROW_W-1:0]  nr;
	logic [COL_W-1:0]  nc;

	always_comb begin
		dir   = rw_q ? rdir_q : spin_new_q;
		even  = !row_q[0];
		up    = (row_q == '0) ? ROW_LAST : row_q - 1'b1;
		down  = (row_q == ROW_LAST) ? '0 : row_q + 1'b1;
		right = (col_q == COL_LAST) ? '0 : col_q + 1'b1;
		left  = (col_q == '0) ? COL_LAST : col_q - 1'b1;
		nr    = row_q;
		nc    = col_q;
		case (dir)
			DIR_E: begin
				nc = right;
			end
			DIR_UR: begin
				nr = up;
				nc = even ? right : col_q;
			end
			DIR_UL: begin
				nr = up;
				nc = even ? col_q : left;
			end
			DIR_W: begin
				nc = left;
			end
			DIR_DL: begin
				nr = down;
				nc = even ? col_q : left;
			end
			default: begin
				nr = down;
				nc = even ? right : col_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.neigh) begin
			target_q <= (SITE_W'(nr) * COLS_V) + SITE_W'(nc);
		end
	end

	// Occupancy memory: one write and one registered read per cycle.
	logic              occ_we;
	logic [SITE_W-1:0] occ_wa;
	logic              occ_wd;
	logic [SITE_W-1:0] occ_ra;

	always_comb begin
		occ_we = 1'b0;
		occ_wa = clr_q;
		occ_wd = 1'b0;
		if (cmd.clr) begin
			occ_we = 1'b1;
		end else if (cmd.place_wr) begin
			occ_we = site_ok && p_ok;
			occ_wa = site_addr;
			occ_wd = 1'b1;
		end else if (cmd.vacate) begin
			occ_we = 1'b1;
			occ_wa = loc;
		end else if (cmd.occupy) begin
			occ_we = 1'b1;
			occ_wa = target_q;
			occ_wd = 1'b1;
		end
		occ_ra = cmd.ord_target ? target_q : site_addr;
	end

	always_ff @(posedge clk) begin
		if (occ_we) begin
			occ_mem[occ_wa] <= occ_wd;
		end
		if (cmd.ord_site || cmd.ord_target) begin
			occ_rd_q <= occ_mem[occ_ra];
		end
	end

	// Particle memory holds site and spin in one word.
	logic               pm_we;
	logic [PWORD_W-1:0] pm_wd;

	always_comb begin
		pm_we = 1'b0;
		pm_wd = {final_site, spin_new_q};
		if (cmd.place_wr) begin
			pm_we = site_ok && p_ok;
			pm_wd = {site_addr, spin_in_q};
		end else if (cmd.pwr_step) begin
			pm_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pm_we) begin
			part_mem[p_addr] <= pm_wd;
		end
		if (cmd.prd) begin
			prd_q <= part_mem[p_addr];
		end
	end

	// Result register; done marks each result for one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= (cmd.res != RES_NONE);
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.res)
			RES_PLACE: begin
				site_out <= site_q;
				spin_out <= spin_in_q;
				moved    <= 1'b0;
				occupied <= 1'b0;
			end
			RES_READ: begin
				site_out <= site_q;
				spin_out <= '0;
				moved    <= 1'b0;
				occupied <= site_ok && occ_rd_q;
			end
			RES_STEP: begin
				site_out <= SITE_PW'(final_site);
				spin_out <= spin_new_q;
				moved    <= !occ_rd_q;
				occupied <= 1'b0;
			end
			RES_ZERO: begin
				site_out <= '0;
				spin_out <= '0;
				moved    <= 1'b0;
				occupied <= 1'b0;
			end
			default: begin
				site_out <= site_out;
			end
		endcase
	end

`include "hex_lattice_gas_particle_step_assert.svh"

	`HLG_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done,
		"result strobe held for more than one cycle")

endmodule

`default_nettype wire
